// ===== rtl/point_to_hex_axial_cell_assert.svh =====
// Assertion macros for the point_to_hex_axial_cell checker.
`ifndef POINT_TO_HEX_AXIAL_CELL_ASSERT_SVH
`define POINT_TO_HEX_AXIAL_CELL_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PTHAC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pthac assertion failed");

// next-cycle implication, disabled in reset
`define PTHAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pthac assertion failed");

// next-cycle implication, active during reset
`define PTHAC_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("pthac assertion failed");

`endif

// ===== rtl/pthac_pkg.sv =====
`default_nettype none

package pthac_pkg;

    localparam int COORD_W         = 32;
    localparam int SCALE_W         = 32;
    localparam int COORD_FRAC_BITS = 16;
    localparam int SCALE_FRAC_BITS = 24;
    localparam int WORK_FRAC_BITS  = 30;
    localparam int DROP            = COORD_FRAC_BITS + SCALE_FRAC_BITS - WORK_FRAC_BITS;
    localparam int PROD_W          = 64;
    localparam int W30             = PROD_W - DROP;
    localparam int FW              = W30 + 3;
    localparam int IW              = FW - WORK_FRAC_BITS;
    localparam int RW              = IW + 2;
    localparam int ERR_W           = WORK_FRAC_BITS + 1;

    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_R_SCALE = 1'b0,
        REG_Q_SCALE = 1'b1
    } t_cfg_idx;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(32'd16777216);

endpackage

`default_nettype wire

// ===== rtl/pthac_point_if.sv =====
`default_nettype none

interface pthac_point_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [pthac_pkg::COORD_W-1:0]   x_pos;
    logic signed [pthac_pkg::COORD_W-1:0]   y_pos;

    modport source (output valid, output x_pos, output y_pos, input ready);
    modport sink   (input valid, input x_pos, input y_pos, output ready);
endinterface

`default_nettype wire

// ===== rtl/pthac_cell_if.sv =====
`default_nettype none

interface pthac_cell_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [pthac_pkg::COORD_W-1:0]   cell_q;
    logic signed [pthac_pkg::COORD_W-1:0]   cell_r;

    modport source (output valid, output cell_q, output cell_r, input ready);
    modport sink   (input valid, input cell_q, input cell_r, output ready);
endinterface

`default_nettype wire

// ===== rtl/point_to_hex_axial_cell.sv =====
// point_to_hex_axial_cell: maps a Q16.16 point (x_pos, y_pos) to the axial
// coordinates (cell_q, cell_r) of the pointy-top hex cell containing it.
// Channels: i_pt carries points in, o_cell carries cells out; each is a
// valid/ready transfer. Config: i_cfg_we writes i_cfg_data to register
// i_cfg_idx (0 = r_scale, 1 = q_scale, Q8.24); write only while idle.
// Pipeline: multiply, combine, round, rebuild, saturate; the last stage
// is the output register that drives o_cell.
// Throughput: one point per cycle while o_cell.ready is high and the five
// register stages all advance; the 32x33 multipliers sit alone in stage one.
// Stalls: each stage holds when its successor is full and stalled, so
// bubbles are squeezed out; i_pt.ready drops only when all stages and
// the output register are full and o_cell.ready is low. Nothing is lost
// or repeated.
// Reset (i_rst_n low, synchronous): all stages empty, both scales 1.0.
`default_nettype none

module point_to_hex_axial_cell (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [pthac_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [pthac_pkg::SCALE_W-1:0]      i_cfg_data,
    pthac_point_if.sink                             i_pt,
    pthac_cell_if.source                            o_cell
);

    localparam int DROP  = pthac_pkg::DROP;
    localparam int PW    = pthac_pkg::PROD_W;
    localparam int W30   = pthac_pkg::W30;
    localparam int FW    = pthac_pkg::FW;
    localparam int IW    = pthac_pkg::IW;
    localparam int RW    = pthac_pkg::RW;
    localparam int EW    = pthac_pkg::ERR_W;
    localparam int WFB   = pthac_pkg::WORK_FRAC_BITS;
    localparam int CW    = pthac_pkg::COORD_W;

    logic [pthac_pkg::SCALE_W-1:0] r_r_scale;
    logic [pthac_pkg::SCALE_W-1:0] r_q_scale;

    logic r_v1, r_v2, r_v3, r_v4, r_ov;
    logic w_en1, w_en2, w_en3, w_en4, w_en5;

    logic signed [PW-1:0] r_prod_r, r_prod_x;
    logic signed [PW-1:0] n_prod_r, n_prod_x;

    logic signed [W30-1:0] w_r30, w_x30;
    logic signed [FW-1:0]  r_qf, r_rf, r_sf;
    logic signed [FW-1:0]  n_qf, n_rf, n_sf;

    logic signed [FW:0]    w_tq, w_tr, w_ts;
    logic [EW-1:0]         w_fq, w_fr, w_fs;
    logic signed [IW-1:0]  r_iq, r_ir, r_is;
    logic [EW-1:0]         r_eq, r_er, r_es;
    logic [EW-1:0]         n_eq, n_er, n_es;

    logic signed [RW-1:0]  r_q, r_r;
    logic signed [RW-1:0]  n_q, n_r;

    logic signed [CW-1:0]  r_cell_q, r_cell_r;
    logic signed [CW-1:0]  n_cell_q, n_cell_r;

    localparam logic [EW-1:0] HALF = EW'(1) << WFB;

    function automatic logic [EW-1:0] err_of(input logic [EW-1:0] f);
        logic [EW-1:0] e;
        if (f >= HALF) begin
            e = f - HALF;
        end else begin
            e = HALF - f;
        end
        return e;
    endfunction

    // rebuilt coordinates stay within 2^26, so the clamp is a sign extension
    function automatic logic signed [CW-1:0] sat32(input logic signed [RW-1:0] v);
        logic signed [CW-1:0] s;
        s = CW'(v);
        return s;
    endfunction

    // stage enables
    assign w_en5 = !r_ov || o_cell.ready;
    assign w_en4 = !r_v4 || w_en5;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign i_pt.ready = w_en1;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_scale <= pthac_pkg::SCALE_RESET;
            r_q_scale <= pthac_pkg::SCALE_RESET;
        end else if (i_cfg_we) begin
            unique case (pthac_pkg::t_cfg_idx'(i_cfg_idx))
                pthac_pkg::REG_R_SCALE: r_r_scale <= i_cfg_data;
                pthac_pkg::REG_Q_SCALE: r_q_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_pt.valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
            if (w_en5) r_ov <= r_v4;
        end
    end

    // stage 1: products
    always_comb begin
        n_prod_r = i_pt.y_pos * $signed({1'b0, r_r_scale});
        n_prod_x = i_pt.x_pos * $signed({1'b0, r_q_scale});
    end

    // stage 2: floor to 30 fraction bits, form q, r, s with 31
    assign w_r30 = r_prod_r[PW-1:DROP];
    assign w_x30 = r_prod_x[PW-1:DROP];

    always_comb begin
        n_rf = {{2{w_r30[W30-1]}}, w_r30, 1'b0};
        n_qf = $signed({{2{w_x30[W30-1]}}, w_x30, 1'b0})
             - $signed({{3{w_r30[W30-1]}}, w_r30});
        n_sf = FW'(0) - $signed({{2{w_x30[W30-1]}}, w_x30, 1'b0})
             - $signed({{3{w_r30[W30-1]}}, w_r30});
    end

    // stage 3: round half up, rounding errors
    assign w_tq = {r_qf[FW-1], r_qf} + (FW+1)'(HALF);
    assign w_tr = {r_rf[FW-1], r_rf} + (FW+1)'(HALF);
    assign w_ts = {r_sf[FW-1], r_sf} + (FW+1)'(HALF);
    assign w_fq = {1'b0, w_tq[WFB-1:0]} | {w_tq[WFB], {WFB{1'b0}}};
    assign w_fr = {1'b0, w_tr[WFB-1:0]} | {w_tr[WFB], {WFB{1'b0}}};
    assign w_fs = {1'b0, w_ts[WFB-1:0]} | {w_ts[WFB], {WFB{1'b0}}};

    always_comb begin
        n_eq = err_of(w_fq);
        n_er = err_of(w_fr);
        n_es = err_of(w_fs);
    end

    // stage 4: rebuild the coordinate with the largest error
    always_comb begin
        n_q = RW'(r_iq);
        n_r = RW'(r_ir);
        if (r_eq > r_er && r_eq > r_es) begin
            n_q = RW'(0) - RW'(r_ir) - RW'(r_is);
        end else if (r_er > r_es) begin
            n_r = RW'(0) - RW'(r_iq) - RW'(r_is);
        end
    end

    // stage 5: saturate
    always_comb begin
        n_cell_q = sat32(r_q);
        n_cell_r = sat32(r_r);
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_prod_r <= n_prod_r;
            r_prod_x <= n_prod_x;
        end
        if (w_en2) begin
            r_qf <= n_qf;
            r_rf <= n_rf;
            r_sf <= n_sf;
        end
        if (w_en3) begin
            r_iq <= w_tq[FW:WFB+1];
            r_ir <= w_tr[FW:WFB+1];
            r_is <= w_ts[FW:WFB+1];
            r_eq <= n_eq;
            r_er <= n_er;
            r_es <= n_es;
        end
        if (w_en4) begin
            r_q <= n_q;
            r_r <= n_r;
        end
        if (w_en5) begin
            r_cell_q <= n_cell_q;
            r_cell_r <= n_cell_r;
        end
    end

    assign o_cell.valid  = r_ov;
    assign o_cell.cell_q = r_cell_q;
    assign o_cell.cell_r = r_cell_r;

endmodule

`default_nettype wire

// ===== rtl/pthac_chk.sv =====
`default_nettype none

`include "point_to_hex_axial_cell_assert.svh"

module pthac_chk (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_in_ready,
    input wire logic                                i_out_valid,
    input wire logic                                i_out_ready,
    input wire logic signed [pthac_pkg::COORD_W-1:0] i_out_q,
    input wire logic signed [pthac_pkg::COORD_W-1:0] i_out_r
);

    `PTHAC_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n, !i_out_valid)
    `PTHAC_ASSERT_NOW(a_ready_when_out_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready)
    `PTHAC_ASSERT_NOW(a_stall_only_when_blocked, i_clk, i_rst_n, !i_in_ready,
                      i_out_valid && !i_out_ready)
    `PTHAC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
                       i_out_valid && $stable(i_out_q) && $stable(i_out_r))

endmodule

bind point_to_hex_axial_cell pthac_chk u_pthac_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pt.ready),
    .i_out_valid (o_cell.valid),
    .i_out_ready (o_cell.ready),
    .i_out_q     (o_cell.cell_q),
    .i_out_r     (o_cell.cell_r)
);

`default_nettype wire

// ===== verif/point_to_hex_axial_cell_tb.sv =====
`default_nettype none

module point_to_hex_axial_cell_tb;

    localparam longint HALF_UNIT = 64'sd1 <<< 30;
    localparam longint FRAC_MASK = (64'sd1 <<< 31) - 64'sd1;
    localparam longint Q_MAX     = 64'sd2147483647;
    localparam longint Q_MIN     = -64'sd2147483648;
    localparam logic signed [pthac_pkg::COORD_W-1:0] C_ONE  = 32'sh0001_0000;
    localparam logic signed [pthac_pkg::COORD_W-1:0] C_HALF = 32'sh0000_8000;
    localparam logic signed [pthac_pkg::COORD_W-1:0] C_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [pthac_pkg::COORD_W-1:0] C_MIN  = 32'sh8000_0000;

    typedef struct {
        logic signed [pthac_pkg::COORD_W-1:0] x;
        logic signed [pthac_pkg::COORD_W-1:0] y;
    } t_point;

    typedef struct {
        logic signed [pthac_pkg::COORD_W-1:0] q;
        logic signed [pthac_pkg::COORD_W-1:0] r;
    } t_cell;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             cfg_we;
    logic [pthac_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [pthac_pkg::SCALE_W-1:0]    cfg_data;

    pthac_point_if pt_if ();
    pthac_cell_if  cell_if ();

    point_to_hex_axial_cell i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pt       (pt_if),
        .o_cell     (cell_if)
    );

    t_point                        pending_points[$];
    t_cell                         expected_cells[$];
    logic [pthac_pkg::SCALE_W-1:0] r_scale_cfg;
    logic [pthac_pkg::SCALE_W-1:0] q_scale_cfg;
    int                            send_idle_pct;
    int                            recv_stall_pct;
    bit                            pt_taken;
    bit                            pressure_go;
    bit                            hold_off;
    int                            fail_count;
    int                            points_sent;
    int                            cells_checked;
    int                            scale_writes;
    int                            input_stalls;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // floor(v + 1/2) on 31 fraction bits, with |error| in 2^-31 units
    function automatic longint round_half_up(input longint v, output longint err);
        longint t;
        longint frac;
        t    = v + HALF_UNIT;
        frac = t & FRAC_MASK;
        err  = (frac >= HALF_UNIT) ? frac - HALF_UNIT : HALF_UNIT - frac;
        return t >>> 31;
    endfunction

    function automatic logic signed [pthac_pkg::COORD_W-1:0] clamp32(input longint v);
        if (v > Q_MAX) v = Q_MAX;
        if (v < Q_MIN) v = Q_MIN;
        return v[pthac_pkg::COORD_W-1:0];
    endfunction

    function automatic t_cell hex_cell_of(input t_point p);
        longint r30, x30, rf, qf, sf;
        longint q, r, s, qe, re, se;
        t_cell  c;
        r30 = (longint'(p.y) * longint'({32'b0, r_scale_cfg})) >>> pthac_pkg::DROP;
        x30 = (longint'(p.x) * longint'({32'b0, q_scale_cfg})) >>> pthac_pkg::DROP;
        rf  = r30 * 2;
        qf  = x30 * 2 - r30;
        sf  = -qf - rf;
        q   = round_half_up(qf, qe);
        r   = round_half_up(rf, re);
        s   = round_half_up(sf, se);
        if (qe > re && qe > se) begin
            q = -r - s;
        end else if (re > se) begin
            r = -q - s;
        end
        c.q = clamp32(q);
        c.r = clamp32(r);
        return c;
    endfunction

    function automatic logic signed [pthac_pkg::COORD_W-1:0] random_coord();
        logic signed [pthac_pkg::COORD_W-1:0] v;
        case ($urandom_range(9))
            0, 1: v = $urandom;
            2, 3, 4, 5, 6: v = int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            7, 8: v = (int'($urandom_range(0, 64)) - 32) <<< 14;
            default: begin
                case ($urandom_range(4))
                    0: v = C_MIN;
                    1: v = C_MAX;
                    2: v = '0;
                    3: v = -1;
                    default: v = 1;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [pthac_pkg::SCALE_W-1:0] random_scale();
        if ($urandom_range(2) == 0) return $urandom;
        return $urandom_range(32'h0010_0000, 32'h0800_0000);
    endfunction

    task automatic add_point(input logic signed [pthac_pkg::COORD_W-1:0] x,
                             input logic signed [pthac_pkg::COORD_W-1:0] y);
        t_point p;
        p.x = x;
        p.y = y;
        pending_points.push_back(p);
    endtask

    task automatic write_scale(input pthac_pkg::t_cfg_idx idx,
                               input logic [pthac_pkg::SCALE_W-1:0] val);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        @(negedge i_clk);
        cfg_we = 1'b0;
        if (idx == pthac_pkg::REG_R_SCALE) r_scale_cfg = val;
        else q_scale_cfg = val;
        scale_writes++;
    endtask

    task automatic drain();
        while (pending_points.size() != 0 || expected_cells.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic run_phase(input int n, input int send_pct, input int recv_pct,
                             input bit squeeze);
        @(posedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < n; i++) add_point(random_coord(), random_coord());
        if (squeeze) pressure_go = 1'b1;
        drain();
    endtask

    task automatic report_mismatch(input string field,
                                   input logic signed [pthac_pkg::COORD_W-1:0] want,
                                   input logic signed [pthac_pkg::COORD_W-1:0] got);
        fail_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    // point channel driver: valid holds until the transfer happens
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pt_if.valid <= 1'b0;
        end else if (!pt_if.valid || pt_taken) begin
            if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                pt_if.valid <= 1'b1;
                pt_if.x_pos <= pending_points[0].x;
                pt_if.y_pos <= pending_points[0].y;
            end else begin
                pt_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) cell_if.ready <= 1'b0;
        else cell_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // long receiver hold-off, once, so the pipeline backs up into the input
    initial begin
        hold_off = 1'b0;
        wait (pressure_go);
        hold_off = 1'b1;
        repeat (40) @(posedge i_clk);
        hold_off = 1'b0;
    end

    always @(posedge i_clk) begin
        t_cell  want;
        t_point p;
        pt_taken <= i_rst_n && pt_if.valid && pt_if.ready;
        if (i_rst_n) begin
            if (cell_if.valid && cell_if.ready) begin
                if (expected_cells.size() == 0) begin
                    fail_count++;
                    $display("%0t: cell transfer with nothing expected, actual q=%0d r=%0d",
                             $time, cell_if.cell_q, cell_if.cell_r);
                end else begin
                    want = expected_cells.pop_front();
                    if (cell_if.cell_q !== want.q) report_mismatch("cell_q", want.q, cell_if.cell_q);
                    if (cell_if.cell_r !== want.r) report_mismatch("cell_r", want.r, cell_if.cell_r);
                    cells_checked++;
                end
            end
            if (pt_if.valid && !pt_if.ready) input_stalls++;
            if (pt_if.valid && pt_if.ready) begin
                p = pending_points.pop_front();
                expected_cells.push_back(hex_cell_of(p));
                points_sent++;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("point_to_hex_axial_cell_tb failed");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = pthac_pkg::REG_R_SCALE;
        cfg_data       = '0;
        r_scale_cfg    = pthac_pkg::SCALE_RESET;
        q_scale_cfg    = pthac_pkg::SCALE_RESET;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pressure_go    = 1'b0;
        fail_count     = 0;
        points_sent    = 0;
        cells_checked  = 0;
        scale_writes   = 0;
        input_stalls   = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed points at reset scales: extremes, halves and ties
        @(posedge i_clk);
        add_point('0, '0);
        add_point(C_MAX, C_MAX);
        add_point(C_MIN, C_MIN);
        add_point(C_MAX, C_MIN);
        add_point(C_MIN, C_MAX);
        add_point(1, -1);
        add_point(-1, 1);
        add_point(C_HALF, '0);
        add_point('0, C_HALF);
        add_point(C_HALF, C_HALF);
        add_point(-C_HALF, -C_HALF);
        add_point(-C_HALF, C_HALF);
        add_point(C_HALF >>> 1, C_HALF + (C_HALF >>> 1));
        add_point(C_ONE + C_HALF, -C_ONE);
        add_point(32'sh7FFF_0000, '0);
        add_point('0, C_MIN);
        add_point(32'sh5555_5555, 32'shAAAA_AAAA);
        add_point(32'shAAAA_AAAA, 32'sh5555_5555);
        add_point(C_ONE * 3, C_ONE * 2);
        add_point(-C_ONE, C_ONE + C_HALF);
        drain();

        run_phase(300, 0, 0, 1'b0);

        // unit edge length
        write_scale(pthac_pkg::REG_R_SCALE, 32'd11184811);
        write_scale(pthac_pkg::REG_Q_SCALE, 32'd9686330);
        run_phase(300, 46, 0, 1'b0);

        write_scale(pthac_pkg::REG_R_SCALE, random_scale());
        write_scale(pthac_pkg::REG_Q_SCALE, random_scale());
        run_phase(300, 0, 46, 1'b0);

        write_scale(pthac_pkg::REG_R_SCALE, '0);
        write_scale(pthac_pkg::REG_Q_SCALE, '0);
        run_phase(60, 27, 27, 1'b0);

        write_scale(pthac_pkg::REG_R_SCALE, '1);
        write_scale(pthac_pkg::REG_Q_SCALE, '1);
        run_phase(200, 27, 27, 1'b0);

        write_scale(pthac_pkg::REG_R_SCALE, '0);
        run_phase(150, 0, 0, 1'b1);

        for (int k = 0; k < 3; k++) begin
            write_scale(pthac_pkg::REG_R_SCALE, random_scale());
            write_scale(pthac_pkg::REG_Q_SCALE, random_scale());
            run_phase(180, 27, 27, 1'b0);
        end

        if (expected_cells.size() != 0) begin
            fail_count++;
            $display("%0t: %0d expected cells never arrived", $time, expected_cells.size());
        end
        $display("%0d points, %0d cells compared, %0d scale register writes",
                 points_sent, cells_checked, scale_writes);
        $display("idle and stall mixes plus one long output hold-off; %0d input stall cycles",
                 input_stalls);
        if (fail_count == 0) begin
            $display("point_to_hex_axial_cell_tb passed");
        end else begin
            $display("point_to_hex_axial_cell_tb failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
